/* design/rmva_pkg.sv */
// Shared widths and operation codes for the running mean and variance accumulator.
package rmva_pkg;

	localparam int OP_W   = 2;
	localparam int CNT_W  = 32;
	localparam int MEAN_W = 32;
	localparam int VAR_W  = 64;

	// Pooled second-moment numerator: a 65-bit term times a count, two such terms summed.
	localparam int ACC_W = 3 * CNT_W + 2;
	// Divisor is at most the exact pooled count, one bit wider than a count.
	localparam int DEN_W = CNT_W + 1;
	localparam int DIV_CNT_W = $clog2(ACC_W + 1);

	localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
	localparam logic [OP_W-1:0] OP_MERGE  = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

endpackage

/* design/running_mean_variance_accumulator_core.sv */
// Running mean and variance accumulator: sequencer, shared multiplier and serial divider.
//
//  channel  handshake                  payload
//  item     item_valid / item_stall    operation, sample, other_count, other_mean,
//                                      other_variance
//  result   result_valid / result_stall count_out, mean_out, variance_out, overflow
//
// A sample divides once for the mean and, when the new count is two or more, once for
// the variance; a merge divides twice; a clear, an empty merge or the unused code 3 none.
// The one-bit-per-cycle restoring divider takes 32 plus 64 steps for a sample, 64 plus 98
// steps for a merge; one 33x33 multiplier is shared by all products.
// arst_n clears the count, mean, sse and variance to zero and empties the result register.
// item_stall is high from acceptance until the result is loaded; a stalled result holds
// the block in its final state, and the next word is taken while a result waits.
module running_mean_variance_accumulator_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 item_valid,
	output logic                                 item_stall,
	input  logic        [rmva_pkg::OP_W-1:0]     operation,
	input  logic signed [rmva_pkg::MEAN_W-1:0]   sample,
	input  logic        [rmva_pkg::CNT_W-1:0]    other_count,
	input  logic signed [rmva_pkg::MEAN_W-1:0]   other_mean,
	input  logic        [rmva_pkg::VAR_W-1:0]    other_variance,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output logic        [rmva_pkg::CNT_W-1:0]    count_out,
	output logic signed [rmva_pkg::MEAN_W-1:0]   mean_out,
	output logic        [rmva_pkg::VAR_W-1:0]    variance_out,
	output logic                                 overflow
);

	localparam int CW = rmva_pkg::CNT_W;
	localparam int MW = rmva_pkg::MEAN_W;
	localparam int VW = rmva_pkg::VAR_W;
	localparam int AW = rmva_pkg::ACC_W;
	localparam int DW = rmva_pkg::DEN_W;
	localparam int KW = rmva_pkg::DIV_CNT_W;

	localparam logic [4:0] ST_IDLE  = 5'd0;
	localparam logic [4:0] ST_START = 5'd1;
	localparam logic [4:0] ST_DIV   = 5'd2;
	localparam logic [4:0] ST_FIN   = 5'd3;
	localparam logic [4:0] S_ABS    = 5'd4;
	localparam logic [4:0] S_MEAN   = 5'd5;
	localparam logic [4:0] S_D2     = 5'd6;
	localparam logic [4:0] S_MUL    = 5'd7;
	localparam logic [4:0] S_SSE    = 5'd8;
	localparam logic [4:0] S_VAR    = 5'd9;
	localparam logic [4:0] M_ABS    = 5'd10;
	localparam logic [4:0] M_PROD   = 5'd11;
	localparam logic [4:0] M_DIVC   = 5'd12;
	localparam logic [4:0] M_CORR   = 5'd13;
	localparam logic [4:0] M_SQ1    = 5'd14;
	localparam logic [4:0] M_T1     = 5'd15;
	localparam logic [4:0] M_SQ2    = 5'd16;
	localparam logic [4:0] M_T2     = 5'd17;
	localparam logic [4:0] M_DIVN   = 5'd18;
	localparam logic [4:0] M_SQ3    = 5'd19;
	localparam logic [4:0] M_VAR    = 5'd20;
	localparam logic [4:0] M_SSE    = 5'd21;
	localparam logic [4:0] MAC_MUL  = 5'd22;
	localparam logic [4:0] MAC_ACC  = 5'd23;

	localparam logic [1:0] LIMB_TOP = 2'd2;

	// control
	logic [4:0]    state_q;
	logic [4:0]    ret_q;
	logic [1:0]    li_q;
	logic [KW-1:0] div_cnt_q;

	// accumulator state
	logic [CW-1:0] cnt_q;
	logic [MW-1:0] mean_q;
	logic [VW-1:0] sse_q;
	logic [VW-1:0] var_q;

	// captured word
	logic [rmva_pkg::OP_W-1:0] op_q;
	logic [MW-1:0] x_q;
	logic [CW-1:0] m_q;
	logic [MW-1:0] mean2_q;
	logic [VW-1:0] ovar_q;

	// work registers
	logic [CW-1:0] cnt_new_q;
	logic [DW-1:0] tot_q;
	logic          flag_q;
	logic [MW:0]   dif_q;
	logic [MW:0]   d2_q;
	logic [CW-1:0] mag_q;
	logic [MW-1:0] newmean_q;
	logic [VW-1:0] prod_q;
	logic [VW:0]   t_q;
	logic [CW-1:0] k_q;
	logic [AW-1:0] acc_q;
	logic [AW-1:0] dvd_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;

	logic          accept;
	logic          out_free;
	logic [CW:0]   cnt_inc;
	logic [DW-1:0] tot_sum;
	logic [MW:0]   start_dif;
	logic [MW:0]   dif_mag;
	logic [MW+1:0] step_q;
	logic [MW+1:0] newmean_sum;
	logic [MW:0]   d2_calc;
	logic signed [MW:0]     mul_a;
	logic signed [MW:0]     mul_b;
	logic signed [2*MW+1:0] mul_p;
	logic          mul_en;
	logic [VW:0]   sse_sum;
	logic [VW-1:0] sse_sat;
	logic [CW-1:0] limb;
	logic [AW-1:0] acc_addend;
	logic [AW-1:0] acc_sum;
	logic [AW:0]   vdiff;
	logic [VW-1:0] var_calc;
	logic          var_flag;
	logic          acc_high;
	logic [DW:0]   div_rs;
	logic          div_ge;
	logic [DW-1:0] div_rem;

	assign accept     = item_valid && !item_stall;
	assign item_stall = (state_q != ST_IDLE);
	assign out_free   = !result_valid || !result_stall;

	always_comb begin
		cnt_inc   = {1'b0, cnt_q} + {{CW{1'b0}}, 1'b1};
		tot_sum   = {1'b0, cnt_q} + {1'b0, m_q};
		if (op_q == rmva_pkg::OP_SAMPLE) begin
			start_dif = {x_q[MW-1], x_q} - {mean_q[MW-1], mean_q};
		end else begin
			start_dif = {mean2_q[MW-1], mean2_q} - {mean_q[MW-1], mean_q};
		end
		dif_mag   = dif_q[MW] ? ({(MW+1){1'b0}} - dif_q) : dif_q;

		// mean moves toward the sample or other group by the truncated quotient
		step_q      = {2'b00, dvd_q[MW-1:0]};
		newmean_sum = {{2{mean_q[MW-1]}}, mean_q}
			+ (dif_q[MW] ? ({(MW+2){1'b0}} - step_q) : step_q);
		d2_calc     = {x_q[MW-1], x_q} - {newmean_q[MW-1], newmean_q};

		sse_sum  = {1'b0, sse_q} + {1'b0, prod_q};
		sse_sat  = sse_sum[VW] ? {VW{1'b1}} : sse_sum[VW-1:0];

		vdiff    = {1'b0, dvd_q} - {{(AW-VW+1){1'b0}}, prod_q};
		acc_high = (acc_q[AW-1:VW] != '0);
		if (vdiff[AW]) begin
			var_calc = '0;
			var_flag = 1'b1;
		end else if (vdiff[AW-1:VW] != '0) begin
			var_calc = {VW{1'b1}};
			var_flag = 1'b1;
		end else begin
			var_calc = vdiff[VW-1:0];
			var_flag = 1'b0;
		end

		div_rs  = {rem_q, dvd_q[AW-1]};
		div_ge  = (div_rs >= {1'b0, den_q});
		div_rem = div_ge ? DW'(div_rs - {1'b0, den_q}) : div_rs[DW-1:0];
	end

	always_comb begin
		case (li_q)
			2'd0:    limb = t_q[CW-1:0];
			2'd1:    limb = t_q[2*CW-1:CW];
			2'd2:    limb = {{(CW-1){1'b0}}, t_q[VW]};
			default: limb = '0;
		endcase
		case (li_q)
			2'd0:    acc_addend = {{(AW-VW){1'b0}}, prod_q};
			2'd1:    acc_addend = {{(AW-VW-CW){1'b0}}, prod_q, {CW{1'b0}}};
			2'd2:    acc_addend = {prod_q[AW-VW-1:0], {VW{1'b0}}};
			default: acc_addend = '0;
		endcase
		acc_sum = acc_q + acc_addend;
	end

	// one shared signed multiplier; squares and unsigned products share it
	always_comb begin
		mul_en = 1'b1;
		unique case (state_q)
			S_MUL: begin
				mul_a = $signed(dif_q);
				mul_b = $signed(d2_q);
			end
			M_PROD: begin
				mul_a = $signed({1'b0, mag_q});
				mul_b = $signed({1'b0, m_q});
			end
			M_SQ1: begin
				mul_a = $signed({mean_q[MW-1], mean_q});
				mul_b = $signed({mean_q[MW-1], mean_q});
			end
			M_SQ2: begin
				mul_a = $signed({mean2_q[MW-1], mean2_q});
				mul_b = $signed({mean2_q[MW-1], mean2_q});
			end
			M_SQ3: begin
				mul_a = $signed({newmean_q[MW-1], newmean_q});
				mul_b = $signed({newmean_q[MW-1], newmean_q});
			end
			MAC_MUL: begin
				mul_a = $signed({1'b0, limb});
				mul_b = $signed({1'b0, k_q});
			end
			default: begin
				mul_a  = '0;
				mul_b  = '0;
				mul_en = 1'b0;
			end
		endcase
		mul_p = mul_a * mul_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			ret_q        <= ST_IDLE;
			li_q         <= '0;
			div_cnt_q    <= '0;
			cnt_q        <= '0;
			mean_q       <= '0;
			sse_q        <= '0;
			var_q        <= '0;
			result_valid <= 1'b0;
		end else begin
			if (state_q == ST_FIN && out_free) begin
				result_valid <= 1'b1;
			end else if (!result_stall) begin
				result_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_START;
					end
				end
				ST_START: begin
					unique case (op_q)
						rmva_pkg::OP_SAMPLE: state_q <= S_ABS;
						rmva_pkg::OP_MERGE:  state_q <= (m_q == '0) ? ST_FIN : M_ABS;
						rmva_pkg::OP_CLEAR: begin
							cnt_q   <= '0;
							mean_q  <= '0;
							sse_q   <= '0;
							var_q   <= '0;
							state_q <= ST_FIN;
						end
						default: state_q <= ST_FIN;
					endcase
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q - KW'(1);
					if (div_cnt_q == KW'(1)) begin
						state_q <= ret_q;
					end
				end
				S_ABS: begin
					div_cnt_q <= KW'(MW);
					ret_q     <= S_MEAN;
					state_q   <= ST_DIV;
				end
				S_MEAN: state_q <= S_D2;
				S_D2:   state_q <= S_MUL;
				S_MUL:  state_q <= S_SSE;
				S_SSE: begin
					sse_q  <= sse_sat;
					cnt_q  <= cnt_new_q;
					mean_q <= newmean_q;
					if (cnt_new_q < CW'(2)) begin
						var_q   <= '0;
						state_q <= ST_FIN;
					end else begin
						div_cnt_q <= KW'(VW);
						ret_q     <= S_VAR;
						state_q   <= ST_DIV;
					end
				end
				S_VAR: begin
					var_q   <= dvd_q[VW-1:0];
					state_q <= ST_FIN;
				end
				M_ABS:  state_q <= M_PROD;
				M_PROD: state_q <= M_DIVC;
				M_DIVC: begin
					div_cnt_q <= KW'(VW);
					ret_q     <= M_CORR;
					state_q   <= ST_DIV;
				end
				M_CORR: state_q <= M_SQ1;
				M_SQ1:  state_q <= M_T1;
				M_T1: begin
					li_q    <= '0;
					ret_q   <= M_SQ2;
					state_q <= MAC_MUL;
				end
				M_SQ2: state_q <= M_T2;
				M_T2: begin
					li_q    <= '0;
					ret_q   <= M_DIVN;
					state_q <= MAC_MUL;
				end
				M_DIVN: begin
					div_cnt_q <= KW'(AW);
					ret_q     <= M_SQ3;
					state_q   <= ST_DIV;
				end
				M_SQ3: state_q <= M_VAR;
				M_VAR: begin
					var_q   <= var_calc;
					li_q    <= '0;
					ret_q   <= M_SSE;
					state_q <= MAC_MUL;
				end
				M_SSE: begin
					sse_q   <= acc_high ? {VW{1'b1}} : acc_q[VW-1:0];
					cnt_q   <= cnt_new_q;
					mean_q  <= newmean_q;
					state_q <= ST_FIN;
				end
				MAC_MUL: state_q <= MAC_ACC;
				MAC_ACC: begin
					if (li_q == LIMB_TOP) begin
						state_q <= ret_q;
					end else begin
						li_q    <= li_q + 2'd1;
						state_q <= MAC_MUL;
					end
				end
				ST_FIN: begin
					// hold until the result register is free
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= operation;
			x_q     <= sample;
			m_q     <= other_count;
			mean2_q <= other_mean;
			ovar_q  <= other_variance;
		end
		if (mul_en) begin
			prod_q <= mul_p[VW-1:0];
		end
		unique case (state_q)
			ST_START: begin
				dif_q <= start_dif;
				tot_q <= tot_sum;
				if (op_q == rmva_pkg::OP_SAMPLE) begin
					cnt_new_q <= cnt_inc[CW] ? rmva_pkg::CNT_MAX : cnt_inc[CW-1:0];
					flag_q    <= cnt_inc[CW];
				end else if (op_q == rmva_pkg::OP_MERGE && m_q != '0) begin
					cnt_new_q <= tot_sum[CW] ? rmva_pkg::CNT_MAX : tot_sum[CW-1:0];
					flag_q    <= tot_sum[CW];
				end else begin
					cnt_new_q <= cnt_q;
					flag_q    <= 1'b0;
				end
			end
			S_ABS: begin
				dvd_q <= {dif_mag[CW-1:0], {(AW-CW){1'b0}}};
				rem_q <= '0;
				den_q <= {1'b0, cnt_new_q};
			end
			ST_DIV: begin
				dvd_q <= {dvd_q[AW-2:0], div_ge};
				rem_q <= div_rem;
			end
			S_MEAN, M_CORR: newmean_q <= newmean_sum[MW-1:0];
			S_D2:  d2_q <= d2_calc;
			S_SSE: begin
				if (sse_sum[VW]) begin
					flag_q <= 1'b1;
				end
				dvd_q <= {sse_sat, {(AW-VW){1'b0}}};
				rem_q <= '0;
				den_q <= {1'b0, cnt_new_q - CW'(1)};
			end
			M_ABS:  mag_q <= dif_mag[CW-1:0];
			M_DIVC: begin
				dvd_q <= {prod_q, {(AW-VW){1'b0}}};
				rem_q <= '0;
				den_q <= tot_q;
			end
			M_T1: begin
				t_q   <= {1'b0, var_q} + {1'b0, prod_q};
				k_q   <= cnt_q;
				acc_q <= '0;
			end
			M_T2: begin
				t_q <= {1'b0, ovar_q} + {1'b0, prod_q};
				k_q <= m_q;
			end
			M_DIVN: begin
				dvd_q <= acc_q;
				rem_q <= '0;
				den_q <= tot_q;
			end
			M_VAR: begin
				if (var_flag) begin
					flag_q <= 1'b1;
				end
				t_q   <= {1'b0, var_calc};
				k_q   <= cnt_new_q;
				acc_q <= '0;
			end
			M_SSE: begin
				if (acc_high) begin
					flag_q <= 1'b1;
				end
			end
			MAC_ACC: acc_q <= acc_sum;
			ST_FIN: begin
				if (out_free) begin
					count_out    <= cnt_q;
					mean_out     <= mean_q;
					variance_out <= var_q;
					overflow     <= flag_q;
				end
			end
			default: begin
			end
		endcase
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> item_stall)
		else $error("block not busy after taking a word");

	a_div_count_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (div_cnt_q != '0))
		else $error("divider running with no steps left");

	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < den_q))
		else $error("divider remainder not below divisor");

	a_limb_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == MAC_MUL || state_q == MAC_ACC) |-> (li_q != 2'd3))
		else $error("limb index out of range");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && out_free) |=> (result_valid && !item_stall))
		else $error("final state left without a result");

endmodule
